### hw/rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

### hw/rtl/lpa_pkg.sv
// Types, constants and single-precision arithmetic functions for the log2 pipeline.
package lpa_pkg;

  localparam int NUM_CELLS = 6;

  localparam logic [31:0] COEF_C0 = 32'hBD0D0CC5;
  localparam logic [31:0] ADD_C [5] = '{
    32'h3EA2ECDD,  // +c1
    32'hBF9DA2C9,  // -c2
    32'h4026537B,  // +c3
    32'hC054BFAD,  // -c4
    32'h4047691A   // +c5
  };
  localparam logic [7:0] EXP_BIAS = 8'd127;

  typedef struct packed {
    logic [31:0] m;
    logic [31:0] frac;
    logic [31:0] ef;
  } side_t;

  typedef struct packed {
    logic        sign;
    logic [7:0]  exp;
    logic [27:0] mag;
  } sum_t;

  function automatic logic [31:0] fmul(input logic [31:0] a, input logic [31:0] b);
    logic        sg;
    logic [23:0] ma;
    logic [23:0] mb;
    logic [47:0] p;
    logic [9:0]  ex;
    logic [23:0] mr;
    logic        g;
    logic        s;
    logic [24:0] rnd;
    sg = a[31] ^ b[31];
    ma = {1'b1, a[22:0]};
    mb = {1'b1, b[22:0]};
    p  = ma * mb;
    ex = {2'b0, a[30:23]} + {2'b0, b[30:23]} - 10'd127;
    if (p[47]) begin
      mr = p[47:24];
      g  = p[23];
      s  = |p[22:0];
      ex = ex + 10'd1;
    end else begin
      mr = p[46:23];
      g  = p[22];
      s  = |p[21:0];
    end
    rnd = {1'b0, mr} + 25'(g & (s | mr[0]));
    if (rnd[24]) begin
      ex = ex + 10'd1;
    end
    if (a[30:23] == 8'd0 || b[30:23] == 8'd0) begin
      return {sg, 31'd0};
    end
    return {sg, ex[7:0], rnd[24] ? 23'd0 : rnd[22:0]};
  endfunction

  function automatic sum_t fadd_align(input logic [31:0] a, input logic [31:0] b);
    sum_t        r;
    logic [31:0] bg;
    logic [31:0] sml;
    logic [26:0] mb;
    logic [26:0] ms;
    logic [26:0] sm;
    logic [7:0]  d;
    if (a[30:0] < b[30:0]) begin
      bg  = b;
      sml = a;
    end else begin
      bg  = a;
      sml = b;
    end
    mb = (bg[30:23] == 8'd0) ? 27'd0 : {1'b1, bg[22:0], 3'b000};
    ms = (sml[30:23] == 8'd0) ? 27'd0 : {1'b1, sml[22:0], 3'b000};
    d  = bg[30:23] - sml[30:23];
    if (d >= 8'd27) begin
      sm = {26'd0, |ms};
    end else begin
      sm = (ms >> d) | 27'(|(ms & ~(27'h7FFFFFF << d)));
    end
    if (bg[31] == sml[31]) begin
      r.mag = {1'b0, mb} + {1'b0, sm};
    end else begin
      r.mag = {1'b0, mb} - {1'b0, sm};
    end
    r.exp  = bg[30:23];
    r.sign = (r.mag == 28'd0) ? (a[31] & b[31]) : bg[31];
    return r;
  endfunction

  function automatic logic [31:0] fadd_norm(input sum_t s);
    logic [26:0] m27;
    logic [8:0]  ex;
    logic [4:0]  lz;
    logic        found;
    logic [23:0] mr;
    logic        g;
    logic        st;
    logic [24:0] rnd;
    lz    = 5'd0;
    found = 1'b0;
    for (int i = 26; i >= 0; i--) begin
      if (!found && s.mag[i]) begin
        lz    = 5'(26 - i);
        found = 1'b1;
      end
    end
    if (s.mag[27]) begin
      m27 = {s.mag[27:2], s.mag[1] | s.mag[0]};
      ex  = {1'b0, s.exp} + 9'd1;
    end else begin
      m27 = s.mag[26:0] << lz;
      ex  = {1'b0, s.exp} - {4'd0, lz};
    end
    mr  = m27[26:3];
    g   = m27[2];
    st  = |m27[1:0];
    rnd = {1'b0, mr} + 25'(g & (st | mr[0]));
    if (rnd[24]) begin
      ex = ex + 9'd1;
    end
    if (s.mag == 28'd0) begin
      return {s.sign, 31'd0};
    end
    return {s.sign, ex[7:0], rnd[24] ? 23'd0 : rnd[22:0]};
  endfunction

  function automatic logic [31:0] exp_to_f32(input logic [7:0] xe);
    logic [8:0] e;
    logic       sg;
    logic [7:0] mag;
    logic [7:0] sh;
    logic [2:0] lz;
    logic       found;
    e     = {1'b0, xe} - {1'b0, EXP_BIAS};
    sg    = e[8];
    mag   = sg ? 8'(-e) : e[7:0];
    lz    = 3'd0;
    found = 1'b0;
    for (int i = 7; i >= 0; i--) begin
      if (!found && mag[i]) begin
        lz    = 3'(7 - i);
        found = 1'b1;
      end
    end
    sh = mag << lz;
    if (mag == 8'd0) begin
      return 32'd0;
    end
    return {sg, 8'(8'd134 - {5'd0, lz}), sh[6:0], 16'd0};
  endfunction

  function automatic logic [31:0] frac_to_f32(input logic [22:0] mt);
    logic [22:0] sh;
    logic [4:0]  lz;
    logic        found;
    lz    = 5'd0;
    found = 1'b0;
    for (int i = 22; i >= 0; i--) begin
      if (!found && mt[i]) begin
        lz    = 5'(22 - i);
        found = 1'b1;
      end
    end
    sh = (mt << lz) << 1;
    if (mt == 23'd0) begin
      return 32'd0;
    end
    return {1'b0, 8'(8'd126 - {3'd0, lz}), sh};
  endfunction

endpackage

### hw/rtl/lpa_cell.sv
// One cell of the chain: rounded multiply, then rounded add, over three register stages.
module lpa_cell import lpa_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_v,
  input  logic [31:0] t_in,
  input  logic [31:0] mul_in,
  input  logic [31:0] add_in,
  input  side_t       side_in,
  output logic        out_v,
  output logic [31:0] t_out,
  output side_t       side_out
);

  logic        v1;
  logic        v2;
  logic [31:0] prod;
  logic [31:0] addend;
  side_t       side1;
  sum_t        sum;
  side_t       side2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1    <= 1'b0;
      v2    <= 1'b0;
      out_v <= 1'b0;
    end else if (en) begin
      v1    <= in_v;
      v2    <= v1;
      out_v <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod     <= fmul(t_in, mul_in);
      addend   <= add_in;
      side1    <= side_in;
      sum      <= fadd_align(prod, addend);
      side2    <= side1;
      t_out    <= fadd_norm(sum);
      side_out <= side2;
    end
  end

endmodule

### hw/rtl/log2_poly_approx_f32.sv
// Top level: pipelined approximate log2 of a single-precision operand.
//   channel  | handshake             | payload
//   input    | in_valid / in_ready   | x_bits
//   output   | out_valid / out_ready | log2_bits
// One item per cycle while the output is not stalled; one entry stage, then six cells of three stages.
// Each cell holds one rounded multiply and one rounded add (five polynomial steps, one final).
// A stalled output freezes the whole pipeline; in_ready is low only then.
// Reset clears the valid bits of every stage; no other state.
`include "assert_macros.svh"
module log2_poly_approx_f32 import lpa_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] x_bits,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] log2_bits
);

  logic        en;
  logic        v_entry;
  side_t       side_entry;
  logic        v    [NUM_CELLS+1];
  logic [31:0] t    [NUM_CELLS+1];
  side_t       side [NUM_CELLS+1];

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_entry <= 1'b0;
    end else if (en) begin
      v_entry <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_entry.m    <= {1'b0, EXP_BIAS, x_bits[22:0]};
      side_entry.frac <= frac_to_f32(x_bits[22:0]);
      side_entry.ef   <= exp_to_f32(x_bits[30:23]);
    end
  end

  assign v[0]    = v_entry;
  assign side[0] = side_entry;
  assign t[0]    = COEF_C0;

  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    if (k < NUM_CELLS - 1) begin : g_poly
      lpa_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .en       (en),
        .in_v     (v[k]),
        .t_in     (t[k]),
        .mul_in   (side[k].m),
        .add_in   (ADD_C[k]),
        .side_in  (side[k]),
        .out_v    (v[k+1]),
        .t_out    (t[k+1]),
        .side_out (side[k+1])
      );
    end else begin : g_last
      lpa_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .en       (en),
        .in_v     (v[k]),
        .t_in     (t[k]),
        .mul_in   (side[k].frac),
        .add_in   (side[k].ef),
        .side_in  (side[k]),
        .out_v    (v[k+1]),
        .t_out    (t[k+1]),
        .side_out (side[k+1])
      );
    end
  end

  assign out_valid = v[NUM_CELLS];
  assign log2_bits = t[NUM_CELLS];

  `ASSERT_IMP(a_no_inf, clk, rst, out_valid, log2_bits[30:23] != 8'hFF, "result not finite")
  `ASSERT_IMP(a_ready_stall, clk, rst, !in_ready, out_valid && !out_ready, "input held without stall")
  `ASSERT_NEXT(a_freeze, clk, rst, out_valid && !out_ready, $stable(v[0]) && $stable(side[0]), "pipeline moved while stalled")

endmodule

### sim/log2_poly_approx_f32_test.sv
// Self-checking testbench for the pipelined single-precision log2 approximation.
module log2_poly_approx_f32_test;
  import lpa_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 40;

  localparam logic [31:0] K_C0  = 32'hBD0D0CC5;
  localparam logic [31:0] K_C1  = 32'h3EA2ECDD;
  localparam logic [31:0] K_C2  = 32'h3F9DA2C9;
  localparam logic [31:0] K_C3  = 32'h4026537B;
  localparam logic [31:0] K_C4  = 32'h4054BFAD;
  localparam logic [31:0] K_C5  = 32'h4047691A;
  localparam logic [31:0] K_ONE = 32'h3F800000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] x_bits = 32'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] log2_bits;

  logic [31:0] log2_expected[$];
  int          error_count = 0;
  int          sent_count = 0;
  int          checked_count = 0;
  int          idle_cycles = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;

  log2_poly_approx_f32 u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .x_bits(x_bits),
    .out_valid(out_valid), .out_ready(out_ready), .log2_bits(log2_bits)
  );

  always #1 clk = ~clk;

  // Round-to-nearest-even single-precision multiply of normal or zero operands.
  function automatic logic [31:0] sp_mul(input logic [31:0] a, input logic [31:0] b);
    logic        sg;
    logic [47:0] p;
    logic [24:0] mt;
    logic        g;
    logic        s;
    int          ex;
    sg = a[31] ^ b[31];
    if (a[30:23] == 8'd0 || b[30:23] == 8'd0) begin
      return {sg, 31'd0};
    end
    p  = {1'b1, a[22:0]} * {1'b1, b[22:0]};
    ex = int'(a[30:23]) + int'(b[30:23]) - 127;
    if (p[47]) begin
      mt = {1'b0, p[47:24]}; g = p[23]; s = |p[22:0]; ex++;
    end else begin
      mt = {1'b0, p[46:23]}; g = p[22]; s = |p[21:0];
    end
    mt = mt + 25'(g & (s | mt[0]));
    if (mt[24]) begin
      mt = mt >> 1; ex++;
    end
    return {sg, 8'(ex), mt[22:0]};
  endfunction

  // Round-to-nearest-even single-precision add of normal or zero operands.
  function automatic logic [31:0] sp_add(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] bg;
    logic [31:0] sm;
    logic [50:0] vb;
    logic [50:0] vs;
    logic [50:0] v;
    logic [24:0] mt;
    logic        g;
    logic        s;
    int          d;
    int          msb;
    int          ex;
    if (a[30:0] == 31'd0 && b[30:0] == 31'd0) begin
      return {a[31] & b[31], 31'd0};
    end
    if (a[30:0] == 31'd0) begin
      return b;
    end
    if (b[30:0] == 31'd0) begin
      return a;
    end
    if (a[30:0] < b[30:0]) begin
      bg = b; sm = a;
    end else begin
      bg = a; sm = b;
    end
    vb = 51'({1'b1, bg[22:0]}) << 26;
    vs = 51'({1'b1, sm[22:0]}) << 26;
    d  = int'(bg[30:23]) - int'(sm[30:23]);
    if (d > 49) begin
      vs = 51'd1;
    end else if (d > 0) begin
      vs = (vs >> d) | 51'(|(vs & ((51'd1 << d) - 51'd1)));
    end
    v = (bg[31] == sm[31]) ? vb + vs : vb - vs;
    if (v == 51'd0) begin
      return 32'd0;
    end
    msb = 0;
    for (int i = 0; i < 51; i++) begin
      if (v[i]) msb = i;
    end
    ex = int'(bg[30:23]) + msb - 49;
    v  = v << (50 - msb);
    mt = {1'b0, v[50:27]};
    g  = v[26];
    s  = |v[25:0];
    mt = mt + 25'(g & (s | mt[0]));
    if (mt[24]) begin
      mt = mt >> 1; ex++;
    end
    return {bg[31], 8'(ex), mt[22:0]};
  endfunction

  function automatic logic [31:0] int_to_sp(input int n);
    logic [7:0] mag;
    int         msb;
    logic [22:0] mt;
    if (n == 0) begin
      return 32'd0;
    end
    mag = 8'((n < 0) ? -n : n);
    msb = 0;
    for (int i = 0; i < 8; i++) begin
      if (mag[i]) msb = i;
    end
    mt = 23'(mag) << (23 - msb);
    return {n < 0, 8'(127 + msb), mt};
  endfunction

  function automatic logic [31:0] predict_log2(input logic [31:0] x);
    logic [31:0] m;
    logic [31:0] t;
    logic [31:0] fr;
    m  = {9'h07F, x[22:0]};
    t  = sp_mul(K_C0, m);
    t  = sp_add(t, K_C1);
    t  = sp_mul(t, m);
    t  = sp_add(t, K_C2 ^ 32'h80000000);
    t  = sp_mul(t, m);
    t  = sp_add(t, K_C3);
    t  = sp_mul(t, m);
    t  = sp_add(t, K_C4 ^ 32'h80000000);
    t  = sp_mul(t, m);
    t  = sp_add(t, K_C5);
    fr = sp_add(m, K_ONE ^ 32'h80000000);
    fr = sp_mul(fr, t);
    return sp_add(int_to_sp(int'(x[30:23]) - 127), fr);
  endfunction

  always @(posedge clk) begin
    if (!rst) begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    logic [31:0] want;
    if (!rst && out_valid && out_ready) begin
      checked_count++;
      if (log2_expected.size() == 0) begin
        $error("unexpected item: log2_bits actual %h", log2_bits);
        error_count++;
      end else begin
        want = log2_expected.pop_front();
        if (log2_bits !== want) begin
          $error("log2_bits mismatch: expected %h actual %h", want, log2_bits);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  task automatic send_operand(input logic [31:0] x);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    x_bits   <= x;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    log2_expected.push_back(predict_log2(x));
    sent_count++;
  endtask

  task automatic finish_stream();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_directed();
    logic [31:0] ops[$] = '{
      32'h00000000, 32'h80000000, 32'h3F800000, 32'hBF800000, 32'h40000000,
      32'h3F7FFFFF, 32'h3FFFFFFF, 32'h00000001, 32'h007FFFFF, 32'h00800000,
      32'h7F800000, 32'hFF800000, 32'h7FC00000, 32'h7FFFFFFF, 32'hFFFFFFFF,
      32'h7F7FFFFF, 32'h3F000000, 32'h41200000, 32'h3FB504F3, 32'h55555555,
      32'hAAAAAAAA, 32'h43000000, 32'h3F800001};
    foreach (ops[i]) send_operand(ops[i]);
  endtask

  task automatic test_random(input int n, input int idle_pct, input int stall_pct);
    logic [31:0] x;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (n) begin
      case ($urandom_range(3))
        0:       x = $urandom;
        1:       x = {1'b0, 8'($urandom_range(100, 154)), 23'($urandom)};
        2:       x = {1'($urandom), 8'($urandom_range(120, 134)), 23'($urandom)};
        default: x = {1'($urandom), 8'($urandom), 23'($urandom_range(7)) << $urandom_range(22)};
      endcase
      send_operand(x);
    end
    finish_stream();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(190, 0, 0);
    test_random(190, 73, 0);
    test_random(190, 0, 73);
    test_random(190, 35, 35);
    recv_stall_pct = 0;
    while (log2_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d operands (edge patterns and random), %0d results checked,", sent_count,
             checked_count);
    $display("under free flow, sparse input, output back-pressure and mixed stalls.");
    if (error_count == 0 && log2_expected.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

### files.f
+incdir+hw/rtl
hw/rtl/lpa_pkg.sv
hw/rtl/lpa_cell.sv
hw/rtl/log2_poly_approx_f32.sv
sim/log2_poly_approx_f32_test.sv
